// File: hw/rtl/lcal_pkg.sv
// ----------------------------------------------------------------------------
// lcal_pkg
// Shared constants and controller/datapath types for the binary-lifting
// lowest-common-ancestor engine.
// ----------------------------------------------------------------------------
package lcal_pkg;

    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 10;
    localparam int MAX_NODES  = 1 << NODE_W;
    localparam int LEVELS_DEF = 10;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD_HEAD,
        OP_LOAD_RD,
        OP_LOAD_WR,
        OP_ORDER,
        OP_LIFT_RD,
        OP_LIFT_WR,
        OP_DESC_RD,
        OP_DESC_STEP,
        OP_FIN_RD,
        OP_FIN_WR,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic is_query;
        logic root_load;
        logic lift_bit;
        logic same;
    } dp_stat_t;

endpackage

// File: hw/rtl/lcal_datapath.sv
// ----------------------------------------------------------------------------
// lcal_datapath
// Depth and ancestor memories, working node registers and the result
// register, stepped by commands from the controller.
// ----------------------------------------------------------------------------
module lcal_datapath #(
    parameter int LEVELS = lcal_pkg::LEVELS_DEF,
    parameter int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic                       clk,
    input  lcal_pkg::dp_cmd_t          cmd,
    input  logic [LVL_W-1:0]           lvl,
    input  logic                       func,
    input  logic [lcal_pkg::NODE_W-1:0] node_a,
    input  logic [lcal_pkg::NODE_W-1:0] node_b,
    output lcal_pkg::dp_stat_t         stat,
    output logic [lcal_pkg::NODE_W-1:0] ancestor
);
    import lcal_pkg::*;

    localparam int ADDR_W   = NODE_W + LVL_W;
    localparam int ANC_SIZE = 1 << ADDR_W;

    logic [NODE_W-1:0]  x_reg, x_next;
    logic [NODE_W-1:0]  y_reg, y_next;
    logic [NODE_W-1:0]  out_reg, out_next;
    logic [DEPTH_W-1:0] diff_reg, diff_next;
    logic               func_reg, func_next;

    logic [DEPTH_W-1:0] depth_mem [MAX_NODES];
    logic [DEPTH_W-1:0] dqa_reg, dqb_reg;
    logic               dza_reg, dzb_reg;
    logic [DEPTH_W-1:0] depth_a, depth_b;
    logic               depth_we;

    logic [NODE_W-1:0]  anc_mem [ANC_SIZE];
    logic [NODE_W-1:0]  aqa_reg, aqb_reg;
    logic               aza_reg, azb_reg;
    logic [NODE_W-1:0]  anc_a, anc_b;
    logic               anc_we;
    logic [LVL_W-1:0]   wr_lvl;
    logic [NODE_W-1:0]  wr_data;
    logic [NODE_W-1:0]  ra_node, rb_node;
    logic [LVL_W-1:0]   ra_lvl, rb_lvl;

    logic [LEVELS+DEPTH_W-1:0] diff_wide;
    logic [LEVELS-1:0]         diff_lv;

    // node zero is the sentinel: its depth and ancestors read as zero
    assign depth_a = dza_reg ? '0 : dqa_reg;
    assign depth_b = dzb_reg ? '0 : dqb_reg;
    assign anc_a   = aza_reg ? '0 : aqa_reg;
    assign anc_b   = azb_reg ? '0 : aqb_reg;

    assign diff_wide = {{LEVELS{1'b0}}, diff_reg};
    assign diff_lv   = diff_wide[LEVELS-1:0];

    always_comb
    begin
        ra_node = x_reg;
        ra_lvl  = lvl;
        rb_node = y_reg;
        rb_lvl  = lvl;
        unique case (cmd.op)
            OP_LOAD_RD:
            begin
                ra_node = y_reg;
                ra_lvl  = lvl - LVL_W'(1);
            end
            OP_LIFT_RD:
            begin
                ra_node = y_reg;
            end
            OP_FIN_RD:
            begin
                ra_lvl = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        out_next  = out_reg;
        diff_next = diff_reg;
        func_next = func_reg;
        depth_we  = 1'b0;
        anc_we    = 1'b0;
        wr_lvl    = lvl;
        wr_data   = anc_a;
        unique case (cmd.op)
            OP_CAPTURE:
            begin
                x_next    = node_a;
                y_next    = node_b;
                func_next = func;
            end
            OP_LOAD_HEAD:
            begin
                depth_we = 1'b1;
                anc_we   = 1'b1;
                wr_lvl   = '0;
                wr_data  = y_reg;
            end
            OP_LOAD_WR:
            begin
                anc_we = 1'b1;
                y_next = anc_a;
            end
            OP_ORDER:
            begin
                if (depth_a > depth_b)
                begin
                    x_next    = y_reg;
                    y_next    = x_reg;
                    diff_next = depth_a - depth_b;
                end
                else
                begin
                    diff_next = depth_b - depth_a;
                end
            end
            OP_LIFT_WR:
            begin
                y_next = anc_a;
            end
            OP_DESC_STEP:
            begin
                if (anc_a != anc_b)
                begin
                    x_next = anc_a;
                    y_next = anc_b;
                end
            end
            OP_FIN_WR:
            begin
                x_next = anc_a;
            end
            OP_PUSH:
            begin
                out_next = x_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        out_reg  <= out_next;
        diff_reg <= diff_next;
        func_reg <= func_next;
    end

    always_ff @(posedge clk)
    begin
        if (depth_we)
        begin
            depth_mem[x_reg] <= depth_b + DEPTH_W'(1);
        end
        dqa_reg <= depth_mem[node_a];
        dqb_reg <= depth_mem[node_b];
        dza_reg <= (node_a == '0);
        dzb_reg <= (node_b == '0);
    end

    always_ff @(posedge clk)
    begin
        if (anc_we)
        begin
            anc_mem[{x_reg, wr_lvl}] <= wr_data;
        end
        aqa_reg <= anc_mem[{ra_node, ra_lvl}];
        aqb_reg <= anc_mem[{rb_node, rb_lvl}];
        aza_reg <= (ra_node == '0);
        azb_reg <= (rb_node == '0);
    end

    assign stat.is_query  = func_reg;
    assign stat.root_load = (x_reg == '0);
    assign stat.lift_bit  = diff_lv[lvl];
    assign stat.same      = (x_reg == y_reg);
    assign ancestor       = out_reg;

endmodule

// File: hw/rtl/lcal_ctrl.sv
// ----------------------------------------------------------------------------
// lcal_ctrl
// Sequencer for loads and queries: level counter, request handshakes and
// datapath commands.
// ----------------------------------------------------------------------------
module lcal_ctrl #(
    parameter int LEVELS = lcal_pkg::LEVELS_DEF,
    parameter int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  lcal_pkg::dp_stat_t stat,
    output lcal_pkg::dp_cmd_t  cmd,
    output logic [LVL_W-1:0]   lvl
);
    import lcal_pkg::*;

    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(LEVELS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_LD_RD,
        S_LD_WR,
        S_LIFT,
        S_LIFT_WR,
        S_CHECK,
        S_DESC_RD,
        S_DESC_STEP,
        S_FIN_RD,
        S_FIN_WR,
        S_OUT
    } state_t;

    state_t           state_reg, state_next;
    logic [LVL_W-1:0] lvl_reg, lvl_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        lvl_next       = lvl_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.is_query)
                begin
                    cmd.op     = OP_ORDER;
                    lvl_next   = '0;
                    state_next = S_LIFT;
                end
                else if (stat.root_load)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.op     = OP_LOAD_HEAD;
                    lvl_next   = LVL_W'(1);
                    state_next = (LEVELS > 1) ? S_LD_RD : S_IDLE;
                end
            end
            S_LD_RD:
            begin
                cmd.op     = OP_LOAD_RD;
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                cmd.op = OP_LOAD_WR;
                if (lvl_reg == LAST_LVL)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_LD_RD;
                end
            end
            S_LIFT:
            begin
                if (stat.lift_bit)
                begin
                    cmd.op     = OP_LIFT_RD;
                    state_next = S_LIFT_WR;
                end
                else if (lvl_reg == LAST_LVL)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                end
            end
            S_LIFT_WR:
            begin
                cmd.op = OP_LIFT_WR;
                if (lvl_reg == LAST_LVL)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    lvl_next   = lvl_reg + LVL_W'(1);
                    state_next = S_LIFT;
                end
            end
            S_CHECK:
            begin
                if (stat.same)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    lvl_next   = LAST_LVL;
                    state_next = S_DESC_RD;
                end
            end
            S_DESC_RD:
            begin
                cmd.op     = OP_DESC_RD;
                state_next = S_DESC_STEP;
            end
            S_DESC_STEP:
            begin
                cmd.op = OP_DESC_STEP;
                if (lvl_reg == '0)
                begin
                    state_next = S_FIN_RD;
                end
                else
                begin
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = S_DESC_RD;
                end
            end
            S_FIN_RD:
            begin
                cmd.op     = OP_FIN_RD;
                state_next = S_FIN_WR;
            end
            S_FIN_WR:
            begin
                cmd.op     = OP_FIN_WR;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_PUSH;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lvl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign lvl       = lvl_reg;

endmodule

// File: hw/rtl/lowest_common_ancestor_lifting_top.sv
// ----------------------------------------------------------------------------
// lowest_common_ancestor_lifting_top
// Binary-lifting lowest-common-ancestor engine: loads build depth and
// power-of-two ancestor rows, queries return the common ancestor.
//
//   channel  signals                          moves
//   in       in_valid / in_ready              func, node_a, node_b request
//   out      out_valid / out_ready            ancestor (queries only)
//
// load: a head step writes depth and level zero, then one memory read and
// one write per higher level; query: order, lift, check, descend, finish,
// bound by the registered reads of the ancestor memory
// reset clears control only; node zero reads as zero, no clearing pass
// a new request is taken while a result waits; a query then waits for the
// output register before it finishes
// ----------------------------------------------------------------------------
module lowest_common_ancestor_lifting_top #(
    parameter int LEVELS = lcal_pkg::LEVELS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [lcal_pkg::NODE_W-1:0] node_a,
    input  logic [lcal_pkg::NODE_W-1:0] node_b,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [lcal_pkg::NODE_W-1:0] ancestor
);
    import lcal_pkg::*;

    localparam int LVL_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [LVL_W-1:0] lvl;

    lcal_ctrl #(
        .LEVELS (LEVELS),
        .LVL_W  (LVL_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd),
        .lvl       (lvl)
    );

    lcal_datapath #(
        .LEVELS (LEVELS),
        .LVL_W  (LVL_W)
    ) u_datapath (
        .clk      (clk),
        .cmd      (cmd),
        .lvl      (lvl),
        .func     (func),
        .node_a   (node_a),
        .node_b   (node_b),
        .stat     (stat),
        .ancestor (ancestor)
    );

endmodule
